/* design/stag_pkg.sv */
`default_nettype none

package stag_pkg;

	localparam int SIZE_W          = 16;
	localparam int STRIDE_W        = 32;
	localparam int IDX_W           = 48;
	localparam int OFS_W           = 48;
	localparam int BASE_W          = 48;
	localparam int MAX_ADDR_W      = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;
	localparam int NUM_CFG_DIMS    = 4;
	localparam int REG_SIZE_BASE   = 0;
	localparam int REG_STRIDE_BASE = 4;

	typedef struct packed {
		logic                  wr_en;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic zero;
		logic wrap;
	} cell_stat_t;

	typedef struct packed {
		logic [IDX_W-1:0] linear_index;
		logic [OFS_W-1:0] strided_offset;
		logic             last;
	} result_t;

endpackage

`default_nettype wire

/* design/stag_cell.sv */
`default_nettype none

module stag_cell #(
	parameter int ADDR_BITS = 48,
	parameter int DIM       = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire stag_pkg::cfg_wr_t     cfg,
	input  wire logic                  start,
	input  wire logic                  carry_in,
	output logic                       carry_out,
	input  wire logic [ADDR_BITS-1:0]  prefix_in,
	output logic      [ADDR_BITS-1:0]  prefix_out,
	output logic      [ADDR_BITS-1:0]  cur_ofs,
	output stag_pkg::cell_stat_t       stat
);

	localparam int IW = stag_pkg::CFG_IDX_W;
	localparam int SW = stag_pkg::SIZE_W;

	logic [SW-1:0]                    size_w;
	logic [stag_pkg::STRIDE_W-1:0]    stride_w;
	logic [stag_pkg::MAX_ADDR_W-1:0]  stride_ext;
	logic [SW-1:0]                    coord_q;
	logic [SW-1:0]                    nxt_coord;
	logic [SW:0]                      coord_inc;
	logic [ADDR_BITS-1:0]             p_q;
	logic [ADDR_BITS-1:0]             nxt_p;
	logic [ADDR_BITS-1:0]             inc_p;
	logic                             wrap;

	if (DIM < stag_pkg::NUM_CFG_DIMS) begin : g_cfg
		localparam logic [IW-1:0] SIZE_IDX   = IW'(stag_pkg::REG_SIZE_BASE + DIM);
		localparam logic [IW-1:0] STRIDE_IDX = IW'(stag_pkg::REG_STRIDE_BASE + DIM);

		logic [SW-1:0]                 size_q;
		logic [stag_pkg::STRIDE_W-1:0] stride_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				size_q   <= SW'(1);
				stride_q <= stag_pkg::STRIDE_W'(1);
			end else if (cfg.wr_en) begin
				if (cfg.index == SIZE_IDX) begin
					size_q <= cfg.data[SW-1:0];
				end
				if (cfg.index == STRIDE_IDX) begin
					stride_q <= cfg.data[stag_pkg::STRIDE_W-1:0];
				end
			end
		end

		assign size_w   = size_q;
		assign stride_w = stride_q;
	end else begin : g_fixed
		assign size_w   = SW'(1);
		assign stride_w = stag_pkg::STRIDE_W'(1);
	end

	assign stride_ext = stag_pkg::MAX_ADDR_W'(stride_w);
	assign coord_inc  = (SW + 1)'(coord_q) + (SW + 1)'(1);
	assign wrap       = coord_inc >= {1'b0, size_w};
	assign inc_p      = p_q + stride_ext[ADDR_BITS-1:0];

	always_comb begin
		priority if (start) begin
			nxt_p     = prefix_in;
			nxt_coord = '0;
		end else if (carry_in && !wrap) begin
			nxt_p     = inc_p;
			nxt_coord = coord_inc[SW-1:0];
		end else if (carry_in) begin
			nxt_p     = prefix_in;
			nxt_coord = '0;
		end else begin
			nxt_p     = p_q;
			nxt_coord = coord_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q <= '0;
			p_q     <= '0;
		end else begin
			coord_q <= nxt_coord;
			p_q     <= nxt_p;
		end
	end

	assign carry_out  = carry_in & wrap;
	assign prefix_out = nxt_p;
	assign cur_ofs    = p_q;
	assign stat.zero  = (size_w == '0);
	assign stat.wrap  = wrap;

endmodule

`default_nettype wire

/* design/stag_skid.sv */
`default_nettype none

module stag_skid (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire stag_pkg::result_t  push_data,
	output logic                    full,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output stag_pkg::result_t       out_data
);

	logic              main_valid_q;
	logic              skid_valid_q;
	stag_pkg::result_t main_q;
	stag_pkg::result_t skid_q;
	logic              take;

	assign take = main_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (push && (!main_valid_q || take)) begin
				main_valid_q <= 1'b1;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end else if (take && skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (take) begin
				main_valid_q <= 1'b0;
			end else begin
				main_valid_q <= main_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (push && (!main_valid_q || take)) begin
			main_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end else if (take && skid_valid_q) begin
			main_q <= skid_q;
		end else begin
			main_q <= main_q;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

endmodule

`default_nettype wire

/* design/strided_tensor_address_generator.sv */
// A result is registered in the output stage before it is offered, behind any result still waiting there.
// Throughput: one item per cycle while in_stall is low; every cell the carry reaches updates in the same cycle.
// The carry and prefix-offset chains through the row of cells set the cycle time.
// A two-entry output stage lets transfers continue while one result waits.
// Reset clears the counters, offsets, base and copy state; sizes and strides reset to one.
`default_nettype none

module strided_tensor_address_generator #(
	parameter int NUM_DIMS  = 4,
	parameter int ADDR_BITS = 48
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [stag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [stag_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              start_req,
	input  wire logic [stag_pkg::BASE_W-1:0]       base_offset,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [stag_pkg::IDX_W-1:0]        linear_index,
	output logic      [stag_pkg::OFS_W-1:0]        strided_offset,
	output logic                                   last
);

	stag_pkg::cfg_wr_t                 cfg_w;
	stag_pkg::cell_stat_t              stat_w [NUM_DIMS];
	stag_pkg::result_t                 res_w;
	stag_pkg::result_t                 out_w;
	logic [NUM_DIMS:0]                 carry_w;
	logic [ADDR_BITS-1:0]              pre_w [NUM_DIMS+1];
	logic [ADDR_BITS-1:0]              ofs_w [NUM_DIMS];
	logic [stag_pkg::MAX_ADDR_W-1:0]   base_ext;
	logic [stag_pkg::MAX_ADDR_W-1:0]   ofs_ext;
	logic [ADDR_BITS-1:0]              base_in;
	logic [ADDR_BITS-1:0]              base_q;
	logic [stag_pkg::IDX_W-1:0]        count_q;
	logic                              active_q;
	logic                              xfer;
	logic                              start;
	logic                              emit;
	logic                              advance;
	logic                              any_zero;
	logic                              all_end;

	assign cfg_w.wr_en = cfg_wr_en;
	assign cfg_w.index = cfg_index;
	assign cfg_w.data  = cfg_data;

	assign base_ext = stag_pkg::MAX_ADDR_W'(base_offset);
	assign base_in  = base_ext[ADDR_BITS-1:0];

	always_comb begin
		any_zero = 1'b0;
		all_end  = 1'b1;
		for (int d = 0; d < NUM_DIMS; d++) begin
			any_zero = any_zero | stat_w[d].zero;
			all_end  = all_end & stat_w[d].wrap;
		end
	end

	assign xfer    = in_valid & ~in_stall;
	assign start   = xfer & start_req;
	assign emit    = xfer & ~start_req & active_q & ~any_zero;
	assign advance = emit & ~all_end;

	assign carry_w[NUM_DIMS] = advance;
	assign pre_w[0]          = start ? base_in : base_q;

	for (genvar d = 0; d < NUM_DIMS; d++) begin : g_cell
		stag_cell #(
			.ADDR_BITS(ADDR_BITS),
			.DIM      (d)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg_w),
			.start     (start),
			.carry_in  (carry_w[d+1]),
			.carry_out (carry_w[d]),
			.prefix_in (pre_w[d]),
			.prefix_out(pre_w[d+1]),
			.cur_ofs   (ofs_w[d]),
			.stat      (stat_w[d])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			count_q  <= '0;
			base_q   <= '0;
		end else begin
			priority if (start) begin
				active_q <= ~any_zero;
				count_q  <= '0;
				base_q   <= base_in;
			end else if (emit) begin
				active_q <= ~all_end;
				count_q  <= count_q + stag_pkg::IDX_W'(1);
			end else if (xfer && any_zero) begin
				active_q <= 1'b0;
			end else begin
				active_q <= active_q;
			end
		end
	end

	assign ofs_ext              = stag_pkg::MAX_ADDR_W'(ofs_w[NUM_DIMS-1]);
	assign res_w.linear_index   = count_q;
	assign res_w.strided_offset = ofs_ext[stag_pkg::OFS_W-1:0];
	assign res_w.last           = all_end;

	stag_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (emit),
		.push_data(res_w),
		.full     (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_w)
	);

	assign linear_index   = out_w.linear_index;
	assign strided_offset = out_w.strided_offset;
	assign last           = out_w.last;

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("Input stalled without a pending result.");

	a_advance_stops: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !carry_w[0])
		else $error("Advance carried out of the outermost dimension.");

	a_last_ends_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && all_end) |=> !active_q)
		else $error("Copy still running after its final element.");

	a_hold_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(!start && !advance) |-> (pre_w[NUM_DIMS] == ofs_w[NUM_DIMS-1]))
		else $error("Offset chain changed without a start or advance.");

endmodule

`default_nettype wire
